[hw/rtl/arbb_pkg.sv]
// Shared widths, register map and reset values for the affine rectangle bounding box.
package arbb_pkg;

	// Field and arithmetic widths
	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_BITS   = FRAC_BITS + 2;
	localparam int OFS_BITS    = COORD_BITS + FRAC_BITS + 1;
	localparam int CORNER_BITS = COORD_BITS + 1;
	localparam int PROD_BITS   = COEF_BITS + CORNER_BITS + 1;
	localparam int ACC_BITS    = PROD_BITS + 2;
	localparam int MAP_BITS    = ACC_BITS - FRAC_BITS;

	// Configuration port
	localparam int DATA_BITS = 32;
	localparam int IDX_BITS  = 3;
	localparam int ADDR_BITS = IDX_BITS + 2;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [OFS_BITS-1:0]  ofs_t;
	typedef logic        [COORD_BITS-1:0] coord_t;
	typedef logic        [CORNER_BITS-1:0] corner_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;
	typedef logic signed [MAP_BITS-1:0]  map_t;

	// Clamped extent on one axis
	typedef struct packed {
		coord_t pos;
		coord_t len;
	} axis_box_t;

	// Register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_COEF_XX      = 3'd0,
		REG_COEF_XY      = 3'd1,
		REG_OFFSET_X     = 3'd2,
		REG_COEF_YX      = 3'd3,
		REG_COEF_YY      = 3'd4,
		REG_OFFSET_Y     = 3'd5,
		REG_FRAME_WIDTH  = 3'd6,
		REG_FRAME_HEIGHT = 3'd7
	} reg_idx_t;

	// Reset values: identity matrix, VGA frame
	localparam coef_t  RST_COEF_ONE     = coef_t'(1) <<< FRAC_BITS;
	localparam coef_t  RST_COEF_ZERO    = '0;
	localparam ofs_t   RST_OFFSET       = '0;
	localparam coord_t RST_FRAME_WIDTH  = coord_t'(640);
	localparam coord_t RST_FRAME_HEIGHT = coord_t'(480);

endpackage

[hw/rtl/affine_rect_bounding_box_top.sv]
// Affine rectangle bounding box: corner mapping, truncation, bounding and frame clamp.
// An accepted word passes the products and mapped-corner stages to box_* and box_valid.
// Throughput: one rectangle per cycle while box_stall is low; four register stages
//   (input, products, mapped corners, result) form an elastic pipeline closing bubbles.
// The eight 18x14 signed products of the products stage set the clock period.
// Reset (arst_n low): all stage valids clear, matrix returns to identity with zero
//   offset, frame to 640x480.
module affine_rect_bounding_box_top
	import arbb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// APB-style configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	// Rectangle channel
	input  logic                 rect_valid,
	output logic                 rect_stall,
	input  logic [COORD_BITS-1:0] rect_x,
	input  logic [COORD_BITS-1:0] rect_y,
	input  logic [COORD_BITS-1:0] rect_width,
	input  logic [COORD_BITS-1:0] rect_height,
	// Box channel
	output logic                 box_valid,
	input  logic                 box_stall,
	output logic [COORD_BITS-1:0] box_x,
	output logic [COORD_BITS-1:0] box_y,
	output logic [COORD_BITS-1:0] box_width,
	output logic [COORD_BITS-1:0] box_height
);

	// Configuration registers
	coef_t  coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	ofs_t   offset_x_q, offset_y_q;
	coord_t frame_width_q, frame_height_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	// Pipeline stages
	logic    valid_s1, valid_s2, valid_s3;
	logic    ready_s1, ready_s2, ready_s3, ready_s4;
	corner_t x0_s1, x1_s1, y0_s1, y1_s1;
	prod_t   prod_x_s2 [4];
	prod_t   prod_y_s2 [4];
	map_t    map_x_s3 [4];
	map_t    map_y_s3 [4];
	map_t    map_x_c [4];
	map_t    map_y_c [4];
	axis_box_t box_x_c, box_y_c;

	// Truncate a fixed-point sum toward zero
	function automatic map_t trunc_zero(input acc_t a);
		map_t q;
		q = map_t'(a >>> FRAC_BITS);
		if (a[ACC_BITS-1] && (|a[FRAC_BITS-1:0])) begin
			q = q + map_t'(1);
		end
		return q;
	endfunction

	// Bounding interval of four points, seeded at the frame, clamped to [0, limit]
	function automatic axis_box_t bound_axis(input map_t v0, input map_t v1,
			input map_t v2, input map_t v3, input coord_t limit);
		map_t      lim;
		map_t      lo;
		map_t      hi;
		map_t      diff;
		axis_box_t r;
		lim = map_t'({1'b0, limit});
		lo  = lim;
		hi  = '0;
		if (v0 < lo) lo = v0;
		if (v1 < lo) lo = v1;
		if (v2 < lo) lo = v2;
		if (v3 < lo) lo = v3;
		if (v0 > hi) hi = v0;
		if (v1 > hi) hi = v1;
		if (v2 > hi) hi = v2;
		if (v3 > hi) hi = v3;
		if (lo < 0) lo = '0;
		if (hi > lim) hi = lim;
		if (hi < lo) hi = lo;
		diff  = hi - lo;
		r.pos = lo[COORD_BITS-1:0];
		r.len = diff[COORD_BITS-1:0];
		return r;
	endfunction

	// Decode register writes
	assign cfg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q      <= RST_COEF_ONE;
			coef_xy_q      <= RST_COEF_ZERO;
			offset_x_q     <= RST_OFFSET;
			coef_yx_q      <= RST_COEF_ZERO;
			coef_yy_q      <= RST_COEF_ONE;
			offset_y_q     <= RST_OFFSET;
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_COEF_XX:      coef_xx_q      <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_COEF_XY:      coef_xy_q      <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_OFFSET_X:     offset_x_q     <= ofs_t'(pwdata[OFS_BITS-1:0]);
				REG_COEF_YX:      coef_yx_q      <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_COEF_YY:      coef_yy_q      <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_OFFSET_Y:     offset_y_q     <= ofs_t'(pwdata[OFS_BITS-1:0]);
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[COORD_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back, sign-extended for the signed registers
	always_comb begin
		case (cfg_idx)
			REG_COEF_XX:      prdata = DATA_BITS'(coef_xx_q);
			REG_COEF_XY:      prdata = DATA_BITS'(coef_xy_q);
			REG_OFFSET_X:     prdata = DATA_BITS'(offset_x_q);
			REG_COEF_YX:      prdata = DATA_BITS'(coef_yx_q);
			REG_COEF_YY:      prdata = DATA_BITS'(coef_yy_q);
			REG_OFFSET_Y:     prdata = DATA_BITS'(offset_y_q);
			REG_FRAME_WIDTH:  prdata = DATA_BITS'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_BITS'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// Elastic handshake: a stage loads when empty or when the next one moves
	assign ready_s4   = !box_valid || !box_stall;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign rect_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			box_valid <= 1'b0;
		end else begin
			if (ready_s1) valid_s1  <= rect_valid;
			if (ready_s2) valid_s2  <= valid_s1;
			if (ready_s3) valid_s3  <= valid_s2;
			if (ready_s4) box_valid <= valid_s3;
		end
	end

	// Stage 1: register the corner coordinates
	always_ff @(posedge clk) begin
		if (ready_s1 && rect_valid) begin
			x0_s1 <= corner_t'(rect_x);
			y0_s1 <= corner_t'(rect_y);
			x1_s1 <= corner_t'(rect_x) + corner_t'(rect_width);
			y1_s1 <= corner_t'(rect_y) + corner_t'(rect_height);
		end
	end

	// Stage 2: the eight coefficient products shared by the four corners
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_x_s2[0] <= coef_xx_q * $signed({1'b0, x0_s1});
			prod_x_s2[1] <= coef_xx_q * $signed({1'b0, x1_s1});
			prod_x_s2[2] <= coef_xy_q * $signed({1'b0, y0_s1});
			prod_x_s2[3] <= coef_xy_q * $signed({1'b0, y1_s1});
			prod_y_s2[0] <= coef_yx_q * $signed({1'b0, x0_s1});
			prod_y_s2[1] <= coef_yx_q * $signed({1'b0, x1_s1});
			prod_y_s2[2] <= coef_yy_q * $signed({1'b0, y0_s1});
			prod_y_s2[3] <= coef_yy_q * $signed({1'b0, y1_s1});
		end
	end

	// Stage 3: sum each corner's row and truncate toward zero
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			map_x_c[i] = trunc_zero(acc_t'(prod_x_s2[i % 2]) + acc_t'(prod_x_s2[2 + i / 2])
				+ acc_t'(offset_x_q));
			map_y_c[i] = trunc_zero(acc_t'(prod_y_s2[i % 2]) + acc_t'(prod_y_s2[2 + i / 2])
				+ acc_t'(offset_y_q));
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			map_x_s3 <= map_x_c;
			map_y_s3 <= map_y_c;
		end
	end

	// Stage 4: bound, clamp and hold the result word
	assign box_x_c = bound_axis(map_x_s3[0], map_x_s3[1], map_x_s3[2], map_x_s3[3],
		frame_width_q);
	assign box_y_c = bound_axis(map_y_s3[0], map_y_s3[1], map_y_s3[2], map_y_s3[3],
		frame_height_q);

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			box_x      <= box_x_c.pos;
			box_width  <= box_x_c.len;
			box_y      <= box_y_c.pos;
			box_height <= box_y_c.len;
		end
	end

	// A stage-3 word that moves on must show at the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ready_s4) |=> box_valid)
		else $error("stage 3 word lost on its way to the output");

	// The input side stalls only when stage 1 holds a word
	assert property (@(posedge clk) disable iff (!arst_n)
		rect_stall |-> valid_s1)
		else $error("rect_stall raised with stage 1 empty");

	// A freshly loaded box never reaches past the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ready_s4 && !cfg_wr) |=>
		(({1'b0, box_x} + {1'b0, box_width}) <= {1'b0, frame_width_q}))
		else $error("box extends beyond frame width");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ready_s4 && !cfg_wr) |=>
		(({1'b0, box_y} + {1'b0, box_height}) <= {1'b0, frame_height_q}))
		else $error("box extends beyond frame height");

endmodule
